FILE: src/protobuf_field_stream_parser_macros.svh
// assertion macros for the protobuf field stream parser
// used by protobuf_field_stream_parser.sv, no other dependencies
`ifndef PROTOBUF_FIELD_STREAM_PARSER_MACROS_SVH
`define PROTOBUF_FIELD_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define PBFSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pbfsp_pkg.sv
// shared types and constants of the protobuf field stream parser
// no dependencies
`default_nettype none

package pbfsp_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int PLEN_BITS   = 27;

	localparam logic [PLEN_BITS-1:0] MAX_FIELD_BYTES_RESET = PLEN_BITS'(67108864);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_DELIM   = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [2:0] ERR_TRUNC_VARINT  = 3'd0;
	localparam logic [2:0] ERR_VARINT_WIDE   = 3'd1;
	localparam logic [2:0] ERR_FIELD_NUMBER  = 3'd2;
	localparam logic [2:0] ERR_TRUNC_FIXED64 = 3'd3;
	localparam logic [2:0] ERR_TRUNC_FIXED32 = 3'd4;
	localparam logic [2:0] ERR_BAD_LENGTH    = 3'd5;
	localparam logic [2:0] ERR_OVER_LIMIT    = 3'd6;
	localparam logic [2:0] ERR_UNSUPPORTED   = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_KEY,
		PH_VAL,
		PH_LEN,
		PH_PAY
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [OFFSET_BITS-1:0] total_length;
		logic [63:0]            acc;
		logic [3:0]             vidx;
		logic [31:0]            field_number;
		logic [2:0]             wire_type;
		logic [PLEN_BITS-1:0]   remaining;
	} pbfsp_state_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [31:0]          field_number;
		logic [2:0]           wire_type;
		logic [63:0]          value;
		logic [PLEN_BITS-1:0] payload_length;
		logic [2:0]           error_code;
		logic [31:0]          position;
		logic                 field_last;
		logic                 message_end;
	} pbfsp_result_t;

endpackage

`default_nettype wire

FILE: src/pbfsp_if.sv
// valid/ready channel interfaces: input item, result item, configuration write
// depends on pbfsp_pkg
`default_nettype none

interface pbfsp_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] message_length;
	logic [7:0]  data_byte;

	modport source (output valid, command, message_length, data_byte, input ready);
	modport sink (input valid, command, message_length, data_byte, output ready);
endinterface

interface pbfsp_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     kind;
	logic [31:0]                    field_number;
	logic [2:0]                     wire_type;
	logic [63:0]                    value;
	logic [pbfsp_pkg::PLEN_BITS-1:0] payload_length;
	logic [2:0]                     error_code;
	logic [31:0]                    position;
	logic                           field_last;
	logic                           message_end;

	modport source (output valid, kind, field_number, wire_type, value, payload_length,
		error_code, position, field_last, message_end, input ready);
	modport sink (input valid, kind, field_number, wire_type, value, payload_length,
		error_code, position, field_last, message_end, output ready);
endinterface

interface pbfsp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pbfsp_pkg::PLEN_BITS-1:0] max_field_bytes;

	modport source (output valid, max_field_bytes, input ready);
	modport sink (input valid, max_field_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/pbfsp_step.sv
// per-byte decode step: next parser state and optional result for one transaction
// depends on pbfsp_pkg
`default_nettype none

module pbfsp_step (
	input  pbfsp_pkg::pbfsp_state_t          st,
	input  logic                             command,
	input  logic [31:0]                      message_length,
	input  logic [7:0]                       data_byte,
	input  logic [pbfsp_pkg::PLEN_BITS-1:0]  max_field_bytes,
	output pbfsp_pkg::pbfsp_state_t          nxt,
	output logic                             res_valid,
	output pbfsp_pkg::pbfsp_result_t         res
);
	import pbfsp_pkg::*;

	logic [OFFSET_BITS-1:0] new_off;
	logic [OFFSET_BITS-1:0] rest;
	logic [OFFSET_BITS-1:0] need;
	logic                   at_end;
	logic [5:0]             shamt;
	logic [63:0]            v;
	logic                   num_bad;
	logic [2:0]             wt;

	assign new_off = st.byte_offset + OFFSET_BITS'(1);
	assign at_end  = new_off == st.total_length;
	assign rest    = st.total_length - new_off;
	assign shamt   = 6'({2'b00, st.vidx} * 6'd7);
	assign v       = st.acc | (64'(data_byte[6:0]) << shamt);
	assign num_bad = (v[63:3] == 61'd0) || (v[63:35] != 29'd0);
	assign wt      = v[2:0];
	assign need    = (wt == WT_FIXED64) ? OFFSET_BITS'(8) : OFFSET_BITS'(4);

	function automatic pbfsp_result_t err_result(input logic [2:0] code,
			input logic [OFFSET_BITS-1:0] p);
		pbfsp_result_t r;
		r            = '0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
		r.position   = 32'(p);
		return r;
	endfunction

	always_comb begin
		nxt       = st;
		res       = '0;
		res_valid = 1'b0;
		if (command == CMD_START) begin
			nxt              = '0;
			nxt.phase        = PH_KEY;
			nxt.total_length = OFFSET_BITS'(message_length);
			if (OFFSET_BITS'(message_length) == '0) begin
				nxt.phase       = PH_IDLE;
				res_valid       = 1'b1;
				res.kind        = KIND_END;
				res.message_end = 1'b1;
			end
		end else begin
			case (st.phase)
				PH_PAY: begin
					nxt.byte_offset = new_off;
					nxt.remaining   = st.remaining - PLEN_BITS'(1);
					res_valid       = 1'b1;
					res.kind        = KIND_PAYLOAD;
					res.value       = 64'(data_byte);
					if (nxt.remaining == '0) begin
						res.field_last  = 1'b1;
						res.message_end = at_end;
						nxt.phase       = at_end ? PH_IDLE : PH_KEY;
					end
				end
				PH_KEY, PH_VAL, PH_LEN: begin
					nxt.byte_offset = new_off;
					if (st.vidx >= 4'd9 && data_byte > 8'd1) begin
						res_valid = 1'b1;
						res       = err_result(ERR_VARINT_WIDE, st.byte_offset);
						nxt.phase = PH_IDLE;
					end else if (data_byte[7]) begin
						nxt.acc  = v;
						nxt.vidx = st.vidx + 4'd1;
						if (at_end) begin
							res_valid = 1'b1;
							res       = err_result(ERR_TRUNC_VARINT, new_off);
							nxt.phase = PH_IDLE;
						end
					end else begin
						nxt.acc  = '0;
						nxt.vidx = '0;
						case (st.phase)
							PH_KEY: begin
								nxt.field_number = '0;
								nxt.wire_type    = '0;
								if (num_bad) begin
									res_valid = 1'b1;
									res       = err_result(ERR_FIELD_NUMBER, new_off);
									nxt.phase = PH_IDLE;
								end else begin
									nxt.field_number = v[34:3];
									nxt.wire_type    = wt;
									if (wt == WT_VARINT || wt == WT_DELIM) begin
										if (at_end) begin
											res_valid = 1'b1;
											res       = err_result(ERR_TRUNC_VARINT, new_off);
											nxt.phase = PH_IDLE;
										end else begin
											nxt.phase = (wt == WT_VARINT) ? PH_VAL : PH_LEN;
										end
									end else if (wt == WT_FIXED64 || wt == WT_FIXED32) begin
										res_valid = 1'b1;
										if (rest < need) begin
											res = err_result((wt == WT_FIXED64) ?
												ERR_TRUNC_FIXED64 : ERR_TRUNC_FIXED32, new_off);
											nxt.phase = PH_IDLE;
										end else begin
											res.kind           = KIND_HEADER;
											res.payload_length = PLEN_BITS'(need);
											nxt.remaining      = PLEN_BITS'(need);
											nxt.phase          = PH_PAY;
										end
									end else begin
										res_valid = 1'b1;
										res       = err_result(ERR_UNSUPPORTED, new_off);
										nxt.phase = PH_IDLE;
									end
								end
							end
							PH_VAL: begin
								res_valid       = 1'b1;
								res.kind        = KIND_HEADER;
								res.value       = v;
								res.field_last  = 1'b1;
								res.message_end = at_end;
								nxt.phase       = at_end ? PH_IDLE : PH_KEY;
							end
							default: begin
								res_valid = 1'b1;
								if (v > 64'(max_field_bytes)) begin
									res       = err_result(ERR_OVER_LIMIT, new_off);
									nxt.phase = PH_IDLE;
								end else if (v > 64'(rest)) begin
									res       = err_result(ERR_BAD_LENGTH, new_off);
									nxt.phase = PH_IDLE;
								end else if (v == 64'd0) begin
									res.kind        = KIND_HEADER;
									res.field_last  = 1'b1;
									res.message_end = at_end;
									nxt.phase       = at_end ? PH_IDLE : PH_KEY;
								end else begin
									res.kind           = KIND_HEADER;
									res.payload_length = v[PLEN_BITS-1:0];
									nxt.remaining      = v[PLEN_BITS-1:0];
									nxt.phase          = PH_PAY;
								end
							end
						endcase
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
		res.field_number = nxt.field_number;
		res.wire_type    = nxt.wire_type;
	end

endmodule

`default_nettype wire

FILE: src/pbfsp_out_reg.sv
// one-entry result register that drives the result channel
// depends on pbfsp_pkg and pbfsp_if
`default_nettype none

module pbfsp_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  pbfsp_pkg::pbfsp_result_t res,
	output logic                     can_take,
	pbfsp_out_if.source              result
);
	import pbfsp_pkg::*;

	logic          valid_q;
	pbfsp_result_t res_q;

	assign can_take = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.kind           = res_q.kind;
	assign result.field_number   = res_q.field_number;
	assign result.wire_type      = res_q.wire_type;
	assign result.value          = res_q.value;
	assign result.payload_length = res_q.payload_length;
	assign result.error_code     = res_q.error_code;
	assign result.position       = res_q.position;
	assign result.field_last     = res_q.field_last;
	assign result.message_end    = res_q.message_end;

endmodule

`default_nettype wire

FILE: src/protobuf_field_stream_parser.sv
// Streaming protobuf wire-format parser, one transaction per clock. A start transaction
// (command 0) opens a message of message_length bytes, and an empty message yields an end result;
// each data transaction (command 1) carries one byte and yields at most one result: a field
// header, a payload byte or an error, which halts parsing until the next start. An accepted
// transaction is decoded combinationally, and its result sits in the output register
// from the next cycle on. Input ready stays high unless that register holds an untaken
// result while the result channel is stalled, so a steady one byte per clock is sustained.
// max_field_bytes may be written over the cfg channel whenever the parser is idle.
// depends on pbfsp_pkg, pbfsp_if, pbfsp_step, pbfsp_out_reg and the macros header
`default_nettype none

`include "protobuf_field_stream_parser_macros.svh"

module protobuf_field_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	pbfsp_in_if.sink    item,
	pbfsp_cfg_if.sink   cfg,
	pbfsp_out_if.source result
);
	import pbfsp_pkg::*;

	pbfsp_state_t         st_q;
	pbfsp_state_t         st_nxt;
	pbfsp_result_t        res;
	logic                 res_valid;
	logic                 can_take;
	logic                 item_fire;
	logic [PLEN_BITS-1:0] max_field_bytes_q;

	assign item.ready = can_take;
	assign item_fire  = item.valid && can_take;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_field_bytes_q <= MAX_FIELD_BYTES_RESET;
		end else if (cfg.valid) begin
			max_field_bytes_q <= cfg.max_field_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (item_fire) begin
			st_q <= st_nxt;
		end
	end

	pbfsp_step u_step (
		.st             (st_q),
		.command        (item.command),
		.message_length (item.message_length),
		.data_byte      (item.data_byte),
		.max_field_bytes(max_field_bytes_q),
		.nxt            (st_nxt),
		.res_valid      (res_valid),
		.res            (res)
	);

	pbfsp_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (item_fire && res_valid),
		.res     (res),
		.can_take(can_take),
		.result  (result)
	);

	`PBFSP_ASSERT_NOW(a_pay_remaining, clk, arst_n, st_q.phase == PH_PAY,
		st_q.remaining != '0, "payload phase with nothing remaining")
	`PBFSP_ASSERT_NOW(a_offset_in_range, clk, arst_n, st_q.phase != PH_IDLE,
		st_q.byte_offset < st_q.total_length, "active parse beyond message end")
	`PBFSP_ASSERT_NEXT(a_start_to_key, clk, arst_n,
		item_fire && item.command == CMD_START && OFFSET_BITS'(item.message_length) != '0,
		st_q.phase == PH_KEY, "nonempty start did not enter key phase")
	`PBFSP_ASSERT_NOW(a_error_fields, clk, arst_n, result.valid && result.kind != KIND_ERROR,
		result.error_code == 3'd0 && result.position == 32'd0,
		"error fields set on a non-error result")

endmodule

`default_nettype wire
